// File: rtl/tns_pkg.sv
// Shared types and constants of the tone note sequencer.
// Action, status and phase codes and the clamp limits of the note fields.
// No dependencies.
`default_nettype none

package tns_pkg;

  typedef enum logic [2:0] {
    ACT_CLEAR  = 3'd0,
    ACT_APPEND = 3'd1,
    ACT_PLAY   = 3'd2,
    ACT_STOP   = 3'd3,
    ACT_TICK   = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    STS_NONE     = 3'd0,
    STS_NO_TRACK = 3'd1,
    STS_DONE     = 3'd2,
    STS_STOPPED  = 3'd3,
    STS_SKIPPED  = 3'd4,
    STS_FULL     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_NOTE = 2'd1,
    PH_GAP  = 2'd2
  } phase_t;

  localparam int FREQ_W = 15;
  localparam int MS_W   = 16;
  localparam int LEN_W  = 25;

  localparam logic [FREQ_W-1:0] FREQ_MAX = 15'd20000;
  localparam logic [MS_W-1:0]   MS_MAX   = 16'd60000;
  localparam logic [LEN_W:0]    LEN_MAX  = 26'h1FFFFFF;

  localparam int MS_PER_S    = 1000;
  localparam int ROUND_UP    = 999;
  localparam int RECIP_SHIFT = 36;

endpackage

`default_nettype wire

// File: rtl/tns_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
`default_nettype none

module tns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/tone_note_sequencer_top.sv
// Tone note sequencer: top level with the note table and the play controller.
// Depends on tns_pkg and tns_ram.
//
// Loads notes into a table and plays them back on tick items, one result item
// per input item. For clear, play, stop and tick the accept cycle issues the
// note table read and the next cycle uses the registered read data and loads
// the result. A valid append goes through clamp and scale, a reciprocal
// multiply that turns milliseconds into ticks (rounded up), and the table
// write. The table stores durations and gaps already in ticks.
// While the result register is full and not taken, the final cycle of an item
// holds; a new item is accepted as soon as the previous one is finished, even
// if its result still waits. Table entries are not cleared at reset; only
// entries below the loaded count are ever used.
`default_nettype none

module tone_note_sequencer_top
  import tns_pkg::*;
#(
  parameter int MAX_NOTES        = 256,
  parameter int TICKS_PER_SECOND = 100
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // note_freq[31:0], note_dur[63:32], note_gap[95:64], now_tick[127:96]
  input  wire logic [127:0] in_tdata,
  // action[2:0]
  input  wire logic [2:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // speaker_off[0], speaker_on[1], tone_freq[16:2], is_playing[17],
  // play_phase[19:18], note_index[28:20], notes_loaded[37:29],
  // track_length_ms[62:38], status[65:63], zero[71:66]
  output logic [71:0]       out_tdata
);

  localparam int ADDR_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int IDX_W  = $clog2(MAX_NOTES + 1);
  localparam int TICK_W = $clog2((60000 * TICKS_PER_SECOND + ROUND_UP) / MS_PER_S + 1);
  localparam int PROD_W = $clog2(60000 * TICKS_PER_SECOND + ROUND_UP + 1);
  localparam int ENT_W  = FREQ_W + 2 * TICK_W;
  localparam logic [63:0] RECIP =
    ((64'd1 << RECIP_SHIFT) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_SCALE = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // latched item
  action_t     act_r;
  logic [31:0] freq_raw_r, dur_raw_r, gap_raw_r, now_r;

  // sequencer state
  logic [IDX_W-1:0]  note_total_r, note_total_nxt;
  logic [IDX_W-1:0]  play_index_r, play_index_nxt;
  logic              running_r, running_nxt;
  logic              sounding_r, sounding_nxt;
  phase_t            phase_r, phase_nxt;
  logic [31:0]       deadline_r, deadline_nxt;
  logic [TICK_W-1:0] gap_len_r, gap_len_nxt;
  logic [LEN_W-1:0]  length_r, length_nxt;

  // append datapath
  logic [FREQ_W-1:0] freq_c, freq_c_r;
  logic [MS_W-1:0]   dur_c, gap_c, dur_c_r, gap_c_r;
  logic [PROD_W-1:0] dur_p_r, gap_p_r;
  logic [TICK_W-1:0] dur_tk_r, gap_tk_r;
  logic [31:0]       dur_p32, gap_p32;
  logic [63:0]       dur_q, gap_q;
  logic [LEN_W:0]    len_sum;

  // table
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;
  logic [FREQ_W-1:0] rd_freq;
  logic [TICK_W-1:0] rd_dur, rd_gap;

  // result
  logic              out_valid_r;
  logic [71:0]       out_data_r;
  logic              out_free, accept, commit, append_go;
  logic              res_off, res_on;
  logic [FREQ_W-1:0] res_freq;
  status_t           res_status;
  logic [31:0]       tick_diff;
  logic [IDX_W-1:0]  idx_inc, bn_idx;
  logic              bn_req;
  logic [31:0]       idx_ext, total_ext;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign idx_inc   = play_index_r + IDX_W'(1);
  assign ram_re    = accept;
  assign ram_raddr = (action_t'(in_tuser) == ACT_PLAY) ? '0 : idx_inc[ADDR_W-1:0];
  assign ram_we    = (state_r == S_WRITE) && out_free;
  assign ram_wdata = {freq_c_r, dur_tk_r, gap_tk_r};
  assign rd_freq   = ram_rdata[ENT_W-1 -: FREQ_W];
  assign rd_dur    = ram_rdata[2*TICK_W-1 -: TICK_W];
  assign rd_gap    = ram_rdata[TICK_W-1:0];

  tns_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_NOTES)
  ) u_note_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (note_total_r[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // clamp the raw note fields; negative goes to zero
  always_comb begin
    if (freq_raw_r[31]) begin
      freq_c = '0;
    end else if (freq_raw_r > 32'(FREQ_MAX)) begin
      freq_c = FREQ_MAX;
    end else begin
      freq_c = freq_raw_r[FREQ_W-1:0];
    end
    if (dur_raw_r[31]) begin
      dur_c = '0;
    end else if (dur_raw_r > 32'(MS_MAX)) begin
      dur_c = MS_MAX;
    end else begin
      dur_c = dur_raw_r[MS_W-1:0];
    end
    if (gap_raw_r[31]) begin
      gap_c = '0;
    end else if (gap_raw_r > 32'(MS_MAX)) begin
      gap_c = MS_MAX;
    end else begin
      gap_c = gap_raw_r[MS_W-1:0];
    end
  end

  assign dur_p32 = 32'(dur_c) * 32'(TICKS_PER_SECOND) + 32'(ROUND_UP);
  assign gap_p32 = 32'(gap_c) * 32'(TICKS_PER_SECOND) + 32'(ROUND_UP);
  // divide by 1000 through the reciprocal; exact over the scaled range
  assign dur_q   = 64'(dur_p_r) * RECIP;
  assign gap_q   = 64'(gap_p_r) * RECIP;
  assign len_sum = {1'b0, length_r} + (LEN_W + 1)'(dur_c_r) + (LEN_W + 1)'(gap_c_r);

  assign tick_diff = now_r - deadline_r;

  always_comb begin
    state_nxt      = state_r;
    note_total_nxt = note_total_r;
    play_index_nxt = play_index_r;
    running_nxt    = running_r;
    sounding_nxt   = sounding_r;
    phase_nxt      = phase_r;
    deadline_nxt   = deadline_r;
    gap_len_nxt    = gap_len_r;
    length_nxt     = length_r;
    res_off        = 1'b0;
    res_on         = 1'b0;
    res_freq       = '0;
    res_status     = STS_NONE;
    bn_req         = 1'b0;
    bn_idx         = '0;
    append_go      = 1'b0;
    commit         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (act_r)
          ACT_CLEAR: begin
            if (sounding_r) begin
              res_off = 1'b1;
            end
            sounding_nxt   = 1'b0;
            running_nxt    = 1'b0;
            phase_nxt      = PH_IDLE;
            note_total_nxt = '0;
            length_nxt     = '0;
            play_index_nxt = '0;
          end
          ACT_APPEND: begin
            if (dur_raw_r == 32'd0 || dur_raw_r[31]) begin
              res_status = STS_SKIPPED;
            end else if (note_total_r == IDX_W'(MAX_NOTES)) begin
              res_status = STS_FULL;
            end else begin
              append_go = 1'b1;
            end
          end
          ACT_PLAY: begin
            if (note_total_r == '0) begin
              res_status = STS_NO_TRACK;
            end else if (!running_r) begin
              running_nxt    = 1'b1;
              phase_nxt      = PH_IDLE;
              bn_req         = 1'b1;
              bn_idx         = '0;
            end
          end
          ACT_STOP: begin
            if (sounding_r) begin
              res_off = 1'b1;
            end
            sounding_nxt = 1'b0;
            running_nxt  = 1'b0;
            phase_nxt    = PH_IDLE;
            res_status   = STS_STOPPED;
          end
          ACT_TICK: begin
            if (running_r && phase_r != PH_IDLE && !tick_diff[31]) begin
              case (phase_r)
                PH_NOTE: begin
                  if (sounding_r) begin
                    res_off = 1'b1;
                  end
                  sounding_nxt = 1'b0;
                  if (gap_len_r != '0) begin
                    phase_nxt    = PH_GAP;
                    deadline_nxt = now_r + 32'(gap_len_r);
                  end else begin
                    bn_req = 1'b1;
                    bn_idx = idx_inc;
                  end
                end
                PH_GAP: begin
                  bn_req = 1'b1;
                  bn_idx = idx_inc;
                end
                default: begin
                end
              endcase
            end
          end
          default: begin
          end
        endcase

        // start the note at bn_idx, or finish when past the last one
        if (bn_req) begin
          play_index_nxt = bn_idx;
          if (bn_idx >= note_total_r) begin
            if (sounding_nxt) begin
              res_off = 1'b1;
            end
            sounding_nxt = 1'b0;
            running_nxt  = 1'b0;
            phase_nxt    = PH_IDLE;
            res_status   = STS_DONE;
          end else begin
            gap_len_nxt   = rd_gap;
            phase_nxt     = PH_NOTE;
            deadline_nxt  = now_r + 32'(rd_dur);
            sounding_nxt  = (rd_freq != '0);
            if (rd_freq != '0) begin
              res_on   = 1'b1;
              res_freq = rd_freq;
            end
          end
        end

        if (append_go) begin
          state_nxt = S_SCALE;
        end else if (out_free) begin
          commit    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCALE: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        note_total_nxt = note_total_r + IDX_W'(1);
        length_nxt     = (len_sum > LEN_MAX) ? LEN_MAX[LEN_W-1:0] : len_sum[LEN_W-1:0];
        if (out_free) begin
          commit    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign idx_ext   = 32'(play_index_nxt);
  assign total_ext = 32'(note_total_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      note_total_r <= '0;
      play_index_r <= '0;
      running_r    <= 1'b0;
      sounding_r   <= 1'b0;
      phase_r      <= PH_IDLE;
      deadline_r   <= '0;
      gap_len_r    <= '0;
      length_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_valid_r  <= 1'b1;
        note_total_r <= note_total_nxt;
        play_index_r <= play_index_nxt;
        running_r    <= running_nxt;
        sounding_r   <= sounding_nxt;
        phase_r      <= phase_nxt;
        deadline_r   <= deadline_nxt;
        gap_len_r    <= gap_len_nxt;
        length_r     <= length_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r      <= action_t'(in_tuser);
      freq_raw_r <= in_tdata[31:0];
      dur_raw_r  <= in_tdata[63:32];
      gap_raw_r  <= in_tdata[95:64];
      now_r      <= in_tdata[127:96];
    end
    if (append_go) begin
      freq_c_r <= freq_c;
      dur_c_r  <= dur_c;
      gap_c_r  <= gap_c;
      dur_p_r  <= dur_p32[PROD_W-1:0];
      gap_p_r  <= gap_p32[PROD_W-1:0];
    end
    if (state_r == S_SCALE) begin
      dur_tk_r <= dur_q[RECIP_SHIFT +: TICK_W];
      gap_tk_r <= gap_q[RECIP_SHIFT +: TICK_W];
    end
    if (commit) begin
      out_data_r <= {6'b0, res_status, length_nxt, total_ext[8:0], idx_ext[8:0],
                     phase_nxt, running_nxt, res_freq, res_on, res_off};
    end
  end

endmodule

`default_nettype wire
